>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pswu_pkg.sv
// Shared types, constants and state codes of the pin warp unit.
`timescale 1ns / 1ps
`default_nettype none
package pswu_pkg;

  localparam int MAX_PINS  = 64;
  localparam int PIN_AW    = 6;
  localparam int FRAC_BITS = 12;

  localparam logic [18:0] ONE       = 19'd4096;
  localparam logic [15:0] HALF      = 16'd2048;
  localparam logic [14:0] REACH_RST = 15'd1434;
  localparam logic [15:0] GAIN_RST  = 16'd4096;
  localparam logic [13:0] THREE     = 14'd12288;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_PINS   = 2'd1;
  localparam logic [1:0] CFG_GAIN   = 2'd2;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DX   = 4'd2;
  localparam logic [3:0] S_DY   = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_FD   = 4'd6;
  localparam logic [3:0] S_W1   = 4'd7;
  localparam logic [3:0] S_W2   = 4'd8;
  localparam logic [3:0] S_AX   = 4'd9;
  localparam logic [3:0] S_AY   = 4'd10;
  localparam logic [3:0] S_FL   = 4'd11;
  localparam logic [3:0] S_DV   = 4'd12;
  localparam logic [3:0] S_MUL  = 4'd13;
  localparam logic [3:0] S_RND  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  typedef struct packed {
    logic [15:0] rest_x;
    logic [15:0] rest_y;
    logic [15:0] moved_x;
    logic [15:0] moved_y;
    logic [14:0] reach;
  } pin_t;

  localparam pin_t PIN_RESET = '{HALF, HALF, HALF, HALF, REACH_RST};

endpackage
`default_nettype wire

>>> design/pswu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pswu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> design/pin_smoothstep_point_warp_unit.sv
// Top level of the pin warp unit: sequencer, shared multiplier, sqrt and divider.
//
//   port group        dir   carries
//   s_tvalid/tready   in    tuser: cmd; tdata: pin_index, point, bind, target, reach
//   m_tvalid/tready   out   tdata: out_x, out_y
//   cfg_valid/ready   in    cfg_index, cfg_data
//
// A pin write is taken while idle. A deform item visits its pins one at a time:
// a pin out of reach ends after the 17-step square root, a pin in reach also runs
// the 27-step divider; then the normalize divides, applies the gain and rounds per
// axis. Pass-through points go straight to the output. Reset is synchronous; a result
// in the output register stalls the next deform or pass-through item only at its end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pin_smoothstep_point_warp_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [119:0] s_tdata,   // pin_index, point_x, point_y, bind_x, bind_y,
                                       // target_x, target_y, reach, zero pad
  input  wire logic         s_tuser,   // cmd
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [31:0]  m_tdata,   // out_x, out_y
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  // Input word fields
  logic [5:0]  in_index;
  logic [15:0] in_px, in_py;
  pswu_pkg::pin_t in_pin;
  assign in_index       = s_tdata[5:0];
  assign in_px          = s_tdata[21:6];
  assign in_py          = s_tdata[37:22];
  assign in_pin.rest_x  = s_tdata[53:38];
  assign in_pin.rest_y  = s_tdata[69:54];
  assign in_pin.moved_x = s_tdata[85:70];
  assign in_pin.moved_y = s_tdata[101:86];
  assign in_pin.reach   = s_tdata[116:102];

  // Configuration registers
  logic        enable;
  logic [6:0]  act_pins;
  logic [15:0] gain;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      act_pins <= '0;
      gain     <= pswu_pkg::GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pswu_pkg::CFG_ENABLE: enable   <= cfg_data[0];
        pswu_pkg::CFG_PINS:   act_pins <= cfg_data[6:0];
        pswu_pkg::CFG_GAIN:   gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  logic [3:0]  state;
  logic [15:0] px, py, ox, oy;
  logic [6:0]  pin_cnt, pin_lim;
  logic [63:0] pin_ok;
  logic        vld_q;
  logic [33:0] sq_v, sq_res, sq_bit;
  logic [5:0]  cnt;
  logic [34:0] div_num, div_quo;
  logic [18:0] div_rem, div_den;
  logic        div_neg, axis;
  logic [24:0] ff;
  logic [12:0] w;
  logic signed [35:0] sum_x, sum_y;
  logic [18:0] total;
  logic signed [33:0] preg;

  logic in_acc, wr_en;
  assign s_tready = (state == pswu_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign wr_en    = in_acc && s_tuser;

  // Pin table
  pswu_pkg::pin_t ram_q, pin;
  pswu_ram #(
    .WIDTH($bits(pswu_pkg::pin_t)),
    .DEPTH(pswu_pkg::MAX_PINS)
  ) u_pins (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(in_index),
    .wr_data(in_pin),
    .rd_addr(pin_cnt[5:0]),
    .rd_data(ram_q)
  );
  assign pin = vld_q ? ram_q : pswu_pkg::PIN_RESET;

  // Per-pin differences
  logic [16:0] dx, dy, dmx, dmy;
  assign dx  = {px[15], px} - {pin.rest_x[15], pin.rest_x};
  assign dy  = {py[15], py} - {pin.rest_y[15], pin.rest_y};
  assign dmx = {pin.moved_x[15], pin.moved_x} - {pin.rest_x[15], pin.rest_x};
  assign dmy = {pin.moved_y[15], pin.moved_y} - {pin.rest_y[15], pin.rest_y};

  // Shared multiplier operand select
  logic [25:0] mul_a;
  logic [17:0] mul_b;
  logic signed [43:0] prod;
  logic [12:0] f;
  logic [17:0] dval;
  assign f    = div_quo[12:0];
  assign dval = div_neg ? 18'(-div_quo[17:0]) : div_quo[17:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      pswu_pkg::S_DX: begin
        mul_a = {{9{dx[16]}}, dx};
        mul_b = {dx[16], dx};
      end
      pswu_pkg::S_DY: begin
        mul_a = {{9{dy[16]}}, dy};
        mul_b = {dy[16], dy};
      end
      pswu_pkg::S_W1: begin
        mul_a = {13'd0, f};
        mul_b = {5'd0, f};
      end
      pswu_pkg::S_W2: begin
        mul_a = {1'b0, ff};
        mul_b = {4'd0, pswu_pkg::THREE - {f, 1'b0}};
      end
      pswu_pkg::S_AX: begin
        mul_a = {{9{dmx[16]}}, dmx};
        mul_b = {5'd0, w};
      end
      pswu_pkg::S_AY: begin
        mul_a = {{9{dmy[16]}}, dmy};
        mul_b = {5'd0, w};
      end
      pswu_pkg::S_MUL: begin
        mul_a = {{8{dval[17]}}, dval};
        mul_b = {{2{gain[15]}}, gain};
      end
      default: ;
    endcase
  end
  assign prod = $signed(mul_a) * $signed(mul_b);

  // Square root step
  logic [33:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = sq_v >= sq_t;

  // Divider step
  logic [19:0] dv_t;
  logic        dv_ge;
  logic [18:0] dv_rem_next;
  assign dv_t        = {div_rem, div_num[34]};
  assign dv_ge       = dv_t >= {1'b0, div_den};
  assign dv_rem_next = dv_ge ? 19'(dv_t - {1'b0, div_den}) : dv_t[18:0];

  // Reach check and next pin
  logic [14:0] r_eff;
  logic [6:0]  pin_cnt_next;
  logic        last_pin;
  assign r_eff        = (pin.reach == '0) ? 15'd1 : pin.reach;
  assign pin_cnt_next = pin_cnt + 7'd1;
  assign last_pin     = (pin_cnt_next == pin_lim);

  // Normalize inputs for the current axis
  logic signed [35:0] sum_sel;
  logic [34:0] sum_mag;
  assign sum_sel = axis ? sum_y : sum_x;
  assign sum_mag = sum_sel[35] ? 35'(-sum_sel) : sum_sel[34:0];

  // Gain rounding toward zero and saturation
  logic signed [33:0] rnd;
  logic signed [23:0] sres;
  logic [15:0] p_sel;
  logic [15:0] sat_v;
  assign rnd   = preg[33] ? preg + 34'sd4095 : preg;
  assign p_sel = axis ? py : px;
  assign sres  = {{2{rnd[33]}}, rnd[33:12]} + {{8{p_sel[15]}}, p_sel};
  always_comb begin
    if (sres > 24'sd32767) begin
      sat_v = 16'h7fff;
    end else if (sres < -24'sd32768) begin
      sat_v = 16'h8000;
    end else begin
      sat_v = sres[15:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    vld_q <= pin_ok[pin_cnt[5:0]];
    if (rst) begin
      state    <= pswu_pkg::S_IDLE;
      pin_ok   <= '0;
      m_tvalid <= 1'b0;
      pin_cnt  <= '0;
      axis     <= 1'b0;
    end else begin
      // Raise the result word when the output register is free, drop it once taken
      if (state == pswu_pkg::S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pswu_pkg::S_IDLE: begin
          if (in_acc) begin
            if (s_tuser) begin
              pin_ok[in_index] <= 1'b1;
            end else if (!enable || act_pins == '0) begin
              ox    <= in_px;
              oy    <= in_py;
              state <= pswu_pkg::S_OUT;
            end else begin
              px      <= in_px;
              py      <= in_py;
              pin_cnt <= '0;
              pin_lim <= (act_pins > 7'(pswu_pkg::MAX_PINS)) ?
                         7'(pswu_pkg::MAX_PINS) : act_pins;
              sum_x   <= '0;
              sum_y   <= '0;
              total   <= '0;
              axis    <= 1'b0;
              state   <= pswu_pkg::S_RD;
            end
          end
        end
        pswu_pkg::S_RD: state <= pswu_pkg::S_DX;
        pswu_pkg::S_DX: begin
          sq_v  <= prod[33:0];
          state <= pswu_pkg::S_DY;
        end
        pswu_pkg::S_DY: begin
          sq_v   <= sq_v + prod[33:0];
          sq_res <= '0;
          sq_bit <= 34'h1_0000_0000;
          cnt    <= 6'd16;
          state  <= pswu_pkg::S_SQ;
        end
        pswu_pkg::S_SQ: begin
          if (sq_ge) begin
            sq_v   <= sq_v - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= pswu_pkg::S_CHK;
          end
        end
        pswu_pkg::S_CHK: begin
          if (sq_res >= {19'd0, r_eff}) begin
            pin_cnt <= pin_cnt_next;
            state   <= last_pin ? pswu_pkg::S_FL : pswu_pkg::S_RD;
          end else begin
            div_num <= {15'(r_eff - sq_res[14:0]), 20'd0};
            div_den <= {4'd0, r_eff};
            div_rem <= '0;
            div_quo <= '0;
            cnt     <= 6'd26;
            state   <= pswu_pkg::S_FD;
          end
        end
        pswu_pkg::S_FD, pswu_pkg::S_DV: begin
          div_rem <= dv_rem_next;
          div_num <= {div_num[33:0], 1'b0};
          div_quo <= {div_quo[33:0], dv_ge};
          cnt     <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= (state == pswu_pkg::S_FD) ? pswu_pkg::S_W1 : pswu_pkg::S_MUL;
          end
        end
        pswu_pkg::S_W1: begin
          ff    <= prod[24:0];
          state <= pswu_pkg::S_W2;
        end
        pswu_pkg::S_W2: begin
          w     <= prod[36:24];
          state <= pswu_pkg::S_AX;
        end
        pswu_pkg::S_AX: begin
          sum_x <= sum_x + prod[35:0];
          state <= pswu_pkg::S_AY;
        end
        pswu_pkg::S_AY: begin
          sum_y   <= sum_y + prod[35:0];
          total   <= total + {6'd0, w};
          pin_cnt <= pin_cnt_next;
          state   <= last_pin ? pswu_pkg::S_FL : pswu_pkg::S_RD;
        end
        pswu_pkg::S_FL: begin
          div_num <= sum_mag;
          div_neg <= sum_sel[35];
          div_den <= (total < pswu_pkg::ONE) ? pswu_pkg::ONE : total;
          div_rem <= '0;
          div_quo <= '0;
          cnt     <= 6'd34;
          state   <= pswu_pkg::S_DV;
        end
        pswu_pkg::S_MUL: begin
          preg  <= prod[33:0];
          state <= pswu_pkg::S_RND;
        end
        pswu_pkg::S_RND: begin
          if (axis) begin
            oy    <= sat_v;
            state <= pswu_pkg::S_OUT;
          end else begin
            ox    <= sat_v;
            axis  <= 1'b1;
            state <= pswu_pkg::S_FL;
          end
        end
        pswu_pkg::S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {oy, ox};
            state    <= pswu_pkg::S_IDLE;
          end
        end
        default: state <= pswu_pkg::S_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_pin_cnt_range, pin_cnt <= 7'(pswu_pkg::MAX_PINS), "pin counter past table")
  `ASSERT_ALWAYS(a_weight_range, state != pswu_pkg::S_AY || w <= 13'd4096, "weight above one")
  `ASSERT_NEXT(a_write_stays_idle, in_acc && s_tuser, state == pswu_pkg::S_IDLE, "write left idle")

endmodule
`default_nettype wire
